/* src/rgs_pkg.sv */
// Package for the regression tree split search block.
// Holds widths, codes and the command/status structs used by the top level, controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps
package rgs_pkg;

	localparam int DW    = 128;  // width of the wide accumulators and arithmetic units
	localparam int VW    = 32;   // width of a Q16.16 value
	localparam int MNW   = 13;   // width of the min_node register
	localparam int POSW  = 12;   // width of best_position
	localparam int IMPW  = 17;   // width of improve_fraction
	localparam logic [IMPW-1:0] IMP_ONE     = 17'd65536;
	localparam logic [MNW-1:0]  MIN_NODE_RST = 13'd2;

	typedef enum logic [1:0] {
		MS_NQ = 2'd0,
		MS_SS = 2'd1,
		MS_TT = 2'd2
	} mul_sel_t;

	typedef enum logic {
		DS_SCORE = 1'b0,
		DS_FIN   = 1'b1
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     sum_clr;
		logic     sum_rd;
		logic     sum_sq;
		logic     sum_acc;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     tot_a;
		logic     tot_set;
		logic     p2_init;
		logic     cap0;
		logic     cap1;
		logic     p2_rd;
		logic     p2_mul;
		logic     p2_acc;
		logic     div_start;
		div_sel_t div_sel;
		logic     p2_cmp;
		logic     p2_next;
		logic     imp_zero;
		logic     imp_set;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic sum_last;
		logic mul_busy;
		logic div_busy;
		logic loop_ok;
		logic cand;
		logic total_zero;
	} stat_t;

	typedef enum logic [18:0] {
		ST_IDLE     = 19'b0000000000000000001,
		ST_SUM_RD   = 19'b0000000000000000010,
		ST_SUM_SQ   = 19'b0000000000000000100,
		ST_SUM_ACC  = 19'b0000000000000001000,
		ST_NQ_START = 19'b0000000000000010000,
		ST_NQ_W     = 19'b0000000000000100000,
		ST_SS_W     = 19'b0000000000001000000,
		ST_P2_RD1   = 19'b0000000000010000000,
		ST_P2_CAP1  = 19'b0000000000100000000,
		ST_LOOP     = 19'b0000000001000000000,
		ST_P2_MUL   = 19'b0000000010000000000,
		ST_P2_ACC   = 19'b0000000100000000000,
		ST_P2_T     = 19'b0000001000000000000,
		ST_T_W      = 19'b0000010000000000000,
		ST_DIV_W    = 19'b0000100000000000000,
		ST_P2_NEXT  = 19'b0001000000000000000,
		ST_FIN      = 19'b0010000000000000000,
		ST_FIN_W    = 19'b0100000000000000000,
		ST_EMIT     = 19'b1000000000000000000
	} state_t;

endpackage

/* src/regression_tree_split_search.sv */
// Top level of the regression tree split search block.
// Instantiates rgs_ctrl and rgs_datapath; uses rgs_pkg.
`timescale 1ns / 1ps
// Rows are loaded one per transfer (start high while busy is low), sorted by
// predictor; the row with last_row set ends the load and starts the search,
// during which busy stays high. The search makes a sum pass over the stored
// rows, two serial multiplications for the total, then a scan over the split
// positions with, at every candidate split, one serial multiplication and one
// serial division, and, unless the total is zero, a last division for the
// ratio. The multiplier and divider are bit-serial. The single result is shown
// for exactly one cycle on result_valid; the receiver cannot stall it and must
// take it then. Rows beyond MAX_ROWS are dropped and reported in status.
// min_node is written through the cfg channel, which is always ready, and
// must only be written while the block is idle. There is no clearing pass: a
// read beyond the loaded rows (position 1 when only one row is loaded) is
// never used.
module regression_tree_split_search import rgs_pkg::*; #(
	parameter int MAX_ROWS = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [VW-1:0] predictor_value,
	input  logic signed [VW-1:0] response_value,
	input  logic                 last_row,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [MNW-1:0]       cfg_data,
	output logic                 result_valid,
	output logic [POSW-1:0]      best_position,
	output logic                 goes_right,
	output logic signed [VW-1:0] split_value,
	output logic [IMPW-1:0]      improve_fraction,
	output logic                 status
);

	cmd_t  cmd;
	stat_t stat;

	// The register write never has to wait.
	assign cfg_ready = 1'b1;

	rgs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.last_row (last_row),
		.busy     (busy),
		.cmd      (cmd),
		.stat     (stat)
	);

	rgs_datapath #(
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_we           (cfg_valid & cfg_ready),
		.cfg_data         (cfg_data),
		.predictor_value  (predictor_value),
		.response_value   (response_value),
		.result_valid     (result_valid),
		.best_position    (best_position),
		.goes_right       (goes_right),
		.split_value      (split_value),
		.improve_fraction (improve_fraction),
		.status           (status)
	);

endmodule

/* src/rgs_ctrl.sv */
// Sequencer of the split search: loads rows, then steps the datapath through
// the sum pass, the total, the split scan and the final ratio. Uses rgs_pkg.
`timescale 1ns / 1ps
module rgs_ctrl import rgs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  last_row,
	output logic  busy,
	output cmd_t  cmd,
	input  stat_t stat
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.sum_clr = 1'b1;
				if (start) begin
					cmd.load = 1'b1;
					if (last_row) state_d = ST_SUM_RD;
				end
			end
			ST_SUM_RD: begin
				cmd.sum_rd = 1'b1;
				state_d    = ST_SUM_SQ;
			end
			ST_SUM_SQ: begin
				cmd.sum_sq = 1'b1;
				state_d    = ST_SUM_ACC;
			end
			ST_SUM_ACC: begin
				cmd.sum_acc = 1'b1;
				state_d     = stat.sum_last ? ST_NQ_START : ST_SUM_RD;
			end
			ST_NQ_START: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MS_NQ;
				state_d       = ST_NQ_W;
			end
			ST_NQ_W: begin
				if (!stat.mul_busy) begin
					cmd.tot_a     = 1'b1;
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MS_SS;
					state_d       = ST_SS_W;
				end
			end
			ST_SS_W: begin
				if (!stat.mul_busy) begin
					cmd.tot_set = 1'b1;
					cmd.p2_init = 1'b1;
					state_d     = ST_P2_RD1;
				end
			end
			ST_P2_RD1: begin
				cmd.cap0 = 1'b1;
				state_d  = ST_P2_CAP1;
			end
			ST_P2_CAP1: begin
				cmd.cap1 = 1'b1;
				state_d  = ST_LOOP;
			end
			ST_LOOP: begin
				if (stat.loop_ok) begin
					cmd.p2_rd = 1'b1;
					state_d   = ST_P2_MUL;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_P2_MUL: begin
				cmd.p2_mul = 1'b1;
				state_d    = ST_P2_ACC;
			end
			ST_P2_ACC: begin
				cmd.p2_acc = 1'b1;
				state_d    = ST_P2_T;
			end
			ST_P2_T: begin
				if (stat.cand) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MS_TT;
					state_d       = ST_T_W;
				end else begin
					state_d = ST_P2_NEXT;
				end
			end
			ST_T_W: begin
				if (!stat.mul_busy) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DS_SCORE;
					state_d       = ST_DIV_W;
				end
			end
			ST_DIV_W: begin
				if (!stat.div_busy) begin
					cmd.p2_cmp = 1'b1;
					state_d    = ST_P2_NEXT;
				end
			end
			ST_P2_NEXT: begin
				cmd.p2_next = 1'b1;
				state_d     = ST_LOOP;
			end
			ST_FIN: begin
				if (stat.total_zero) begin
					cmd.imp_zero = 1'b1;
					state_d      = ST_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DS_FIN;
					state_d       = ST_FIN_W;
				end
			end
			ST_FIN_W: begin
				if (!stat.div_busy) begin
					cmd.imp_set = 1'b1;
					state_d     = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* src/rgs_datapath.sv */
// Datapath of the split search: row memories, accumulators, a shared
// bit-serial multiplier and divider, and the result registers. Uses rgs_pkg.
`timescale 1ns / 1ps
module rgs_datapath import rgs_pkg::*; #(
	parameter int MAX_ROWS = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	input  logic                   cfg_we,
	input  logic [MNW-1:0]         cfg_data,
	input  logic signed [VW-1:0]   predictor_value,
	input  logic signed [VW-1:0]   response_value,
	output logic                   result_valid,
	output logic [POSW-1:0]        best_position,
	output logic                   goes_right,
	output logic signed [VW-1:0]   split_value,
	output logic [IMPW-1:0]        improve_fraction,
	output logic                   status
);

	localparam int AW  = $clog2(MAX_ROWS);
	localparam int CW  = $clog2(MAX_ROWS + 1);
	localparam int NLW = 2 * CW;
	localparam int KW  = $clog2(DW + 1);

	logic signed [VW-1:0] pred_mem [MAX_ROWS];
	logic signed [VW-1:0] resp_mem [MAX_ROWS];

	logic [MNW-1:0]       min_node_q;
	logic [CW-1:0]        rows_q;
	logic                 overflow_q;
	logic [CW-1:0]        idx_q;
	logic signed [VW-1:0] pred_rd_q, resp_rd_q;
	logic [AW-1:0]        pred_addr, resp_addr;
	logic                 pred_re, resp_re;

	logic [DW-1:0]        s_q, q_q, tota_q, total_q;
	logic [2*VW-1:0]      sq_s1;
	logic signed [CW+VW:0] ny_s1;
	logic [DW-1:0]        nsl_q, nls_q, best_q;
	logic [NLW-1:0]       nlnr_q;
	logic signed [VW-1:0] pred_cur_q, pred_nxt_q, bp0_q, bp1_q;
	logic [CW-1:0]        bpos_q;
	logic                 right_q, t_neg_q;
	logic [IMPW-1:0]      imp_q;

	logic [DW-1:0]        mul_acc_q, mul_a_q, mul_b_q;
	logic [KW-1:0]        mul_cnt_q;
	logic [DW-1:0]        div_rem_q, div_quo_q, div_den_q;
	logic [KW-1:0]        div_cnt_q;

	logic [DW-1:0]        abs_s, t_w, abs_t, mul_a_d, mul_b_d, div_num_d, div_den_d;
	logic [DW:0]          div_r;
	logic                 div_ge;
	logic [VW-1:0]        abs_y;
	logic [MNW-1:0]       mn;
	logic [CW-1:0]        nl_w, nr_w;
	logic [VW:0]          split_sum;

	// Row memories: one write port for loading, one registered read port each.
	always_ff @(posedge clk) begin
		if (cmd.load && (rows_q < CW'(MAX_ROWS))) begin
			pred_mem[rows_q[AW-1:0]] <= predictor_value;
			resp_mem[rows_q[AW-1:0]] <= response_value;
		end
		if (pred_re) pred_rd_q <= pred_mem[pred_addr];
		if (resp_re) resp_rd_q <= resp_mem[resp_addr];
	end

	always_comb begin
		pred_re   = cmd.p2_init | cmd.cap0 | cmd.p2_rd;
		resp_re   = cmd.sum_rd | cmd.p2_rd;
		resp_addr = idx_q[AW-1:0];
		if (cmd.p2_init) pred_addr = '0;
		else if (cmd.cap0) pred_addr = AW'(1);
		else pred_addr = AW'(idx_q + CW'(1));
	end

	always_comb begin
		abs_s = s_q[DW-1] ? (DW'(0) - s_q) : s_q;
		t_w   = nsl_q - nls_q;
		abs_t = t_w[DW-1] ? (DW'(0) - t_w) : t_w;
		abs_y = resp_rd_q[VW-1] ? (VW'(0) - resp_rd_q) : resp_rd_q;
		mn    = (min_node_q == '0) ? MNW'(1) : min_node_q;
		nl_w  = idx_q + CW'(1);
		nr_w  = rows_q - idx_q - CW'(1);
		case (cmd.mul_sel)
			MS_NQ:   begin mul_a_d = q_q;   mul_b_d = DW'(rows_q); end
			MS_SS:   begin mul_a_d = abs_s; mul_b_d = abs_s;       end
			default: begin mul_a_d = abs_t; mul_b_d = abs_t;       end
		endcase
		if (cmd.div_sel == DS_FIN) begin
			div_num_d = best_q << 16;
			div_den_d = total_q;
		end else begin
			div_num_d = mul_acc_q;
			div_den_d = DW'(nlnr_q);
		end
		div_r     = {div_rem_q, div_quo_q[DW-1]};
		div_ge    = (div_r >= {1'b0, div_den_q});
		split_sum = {bp0_q[VW-1], bp0_q} + {bp1_q[VW-1], bp1_q};
	end

	assign stat.sum_last   = (idx_q == rows_q - CW'(1));
	assign stat.mul_busy   = (mul_cnt_q != '0);
	assign stat.div_busy   = (div_cnt_q != '0);
	assign stat.loop_ok    = ((32'(idx_q) + 32'd1) < 32'(rows_q))
		&& ((32'(rows_q) - 32'(idx_q)) > 32'(mn));
	assign stat.cand       = (pred_nxt_q != pred_cur_q) && ((32'(idx_q) + 32'd1) >= 32'(mn));
	assign stat.total_zero = (total_q == '0);

	// Control state: row count, overflow flag, unit counters, strobe, register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_node_q   <= MIN_NODE_RST;
			rows_q       <= '0;
			overflow_q   <= 1'b0;
			mul_cnt_q    <= '0;
			div_cnt_q    <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit;
			if (cfg_we) min_node_q <= cfg_data;
			if (cmd.load) begin
				if (rows_q < CW'(MAX_ROWS)) rows_q <= rows_q + CW'(1);
				else overflow_q <= 1'b1;
			end
			if (cmd.emit) begin
				rows_q     <= '0;
				overflow_q <= 1'b0;
			end
			if (cmd.mul_start) mul_cnt_q <= KW'(DW);
			else if (mul_cnt_q != '0) mul_cnt_q <= mul_cnt_q - KW'(1);
			if (cmd.div_start) div_cnt_q <= KW'(DW);
			else if (div_cnt_q != '0) div_cnt_q <= div_cnt_q - KW'(1);
		end
	end

	// Shift-add multiplier, one bit of the multiplier each cycle.
	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mul_acc_q <= '0;
			mul_a_q   <= mul_a_d;
			mul_b_q   <= mul_b_d;
		end else if (mul_cnt_q != '0) begin
			if (mul_b_q[0]) mul_acc_q <= mul_acc_q + mul_a_q;
			mul_a_q <= mul_a_q << 1;
			mul_b_q <= mul_b_q >> 1;
		end
	end

	// Restoring divider, one quotient bit each cycle.
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_rem_q <= '0;
			div_quo_q <= div_num_d;
			div_den_q <= div_den_d;
		end else if (div_cnt_q != '0) begin
			div_rem_q <= div_ge ? DW'(div_r - {1'b0, div_den_q}) : div_r[DW-1:0];
			div_quo_q <= {div_quo_q[DW-2:0], div_ge};
		end
	end

	// Accumulators and scan registers.
	always_ff @(posedge clk) begin
		if (cmd.sum_clr) begin
			idx_q <= '0;
			s_q   <= '0;
			q_q   <= '0;
		end
		if (cmd.sum_sq) begin
			sq_s1 <= abs_y * abs_y;
			s_q   <= s_q + {{(DW-VW){resp_rd_q[VW-1]}}, resp_rd_q};
		end
		if (cmd.sum_acc) begin
			q_q   <= q_q + DW'(sq_s1);
			idx_q <= idx_q + CW'(1);
		end
		if (cmd.tot_a) tota_q <= mul_acc_q;
		if (cmd.tot_set) total_q <= tota_q - mul_acc_q;
		if (cmd.p2_init) begin
			idx_q   <= '0;
			nsl_q   <= '0;
			nls_q   <= '0;
			nlnr_q  <= NLW'(rows_q - CW'(1));
			best_q  <= '0;
			bpos_q  <= '0;
			right_q <= 1'b0;
		end
		if (cmd.cap0) begin
			pred_cur_q <= pred_rd_q;
			bp0_q      <= pred_rd_q;
		end
		if (cmd.cap1) bp1_q <= pred_rd_q;
		if (cmd.p2_mul) begin
			ny_s1      <= $signed({1'b0, rows_q}) * resp_rd_q;
			pred_nxt_q <= pred_rd_q;
		end
		if (cmd.p2_acc) begin
			nsl_q <= nsl_q + DW'(ny_s1);
			nls_q <= nls_q + s_q;
		end
		if (cmd.mul_start && (cmd.mul_sel == MS_TT)) t_neg_q <= t_w[DW-1];
		if (cmd.p2_cmp && (div_quo_q > best_q)) begin
			best_q  <= div_quo_q;
			bpos_q  <= idx_q;
			right_q <= ~t_neg_q;
			bp0_q   <= pred_cur_q;
			bp1_q   <= pred_nxt_q;
		end
		if (cmd.p2_next) begin
			pred_cur_q <= pred_nxt_q;
			nlnr_q     <= nlnr_q + NLW'(nr_w) - NLW'(nl_w) - NLW'(1);
			idx_q      <= idx_q + CW'(1);
		end
		if (cmd.imp_zero) imp_q <= '0;
		if (cmd.imp_set) imp_q <= (div_quo_q > DW'(IMP_ONE)) ? IMP_ONE : div_quo_q[IMPW-1:0];
		if (cmd.emit) begin
			best_position    <= POSW'(bpos_q);
			goes_right       <= right_q;
			split_value      <= (rows_q > CW'(1)) ? split_sum[VW:1] : bp0_q;
			improve_fraction <= imp_q;
			status           <= overflow_q;
		end
	end

endmodule

/* src/rgs_checker.sv */
// Port-level checks for the split search block, bound to the top level.
// Uses rgs_pkg.
`timescale 1ns / 1ps
module rgs_checker import rgs_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            last_row,
	input logic            result_valid,
	input logic [IMPW-1:0] improve_fraction
);

	a_search_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_row |=> busy) else $error("search did not start");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result strobe longer than one cycle");

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy) else $error("result shown while busy");

	a_imp_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> improve_fraction <= IMP_ONE) else $error("improve above one");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && last_row)) else $error("busy without last row");

endmodule

bind regression_tree_split_search rgs_checker u_rgs_checker (.*);

/* test/regression_tree_split_search_tb.sv */
// Self-checking testbench for the regression tree split search block.
// Drives data sets of rows, mostly sorted, predicts each best split with its own
// wide-integer model, and checks every result. Depends on rgs_pkg and the RTL.
`timescale 1ns / 1ps
module regression_tree_split_search_tb;
	import rgs_pkg::*;

	localparam int CAPACITY = 4096;
	localparam int STALL_LIMIT = 200000;

	// One row as it travels through the start/busy transfer.
	typedef struct {
		logic signed [VW-1:0] pred;
		logic signed [VW-1:0] resp;
		logic                 last;
	} row_t;

	// One expected split result.
	typedef struct {
		logic [POSW-1:0]      pos;
		logic                 right;
		logic signed [VW-1:0] split;
		logic [IMPW-1:0]      imp;
		logic                 stat;
	} split_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic signed [VW-1:0] predictor_value;
	logic signed [VW-1:0] response_value;
	logic                 last_row;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [MNW-1:0]       cfg_data;
	logic                 result_valid;
	logic [POSW-1:0]      best_position;
	logic                 goes_right;
	logic signed [VW-1:0] split_value;
	logic [IMPW-1:0]      improve_fraction;
	logic                 status;

	row_t   rows_to_send[$];
	split_t splits_due[$];

	// The testbench's own copy of the block state.
	logic signed [VW-1:0] pred_mem [CAPACITY];
	logic signed [VW-1:0] resp_mem [CAPACITY];
	int unsigned          row_count;
	logic                 dropped_rows;
	logic [MNW-1:0]       min_rows;

	int   error_count;
	int   gap_left;
	logic quiet;
	int   stall_cycles;

	regression_tree_split_search i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.predictor_value  (predictor_value),
		.response_value   (response_value),
		.last_row         (last_row),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.result_valid     (result_valid),
		.best_position    (best_position),
		.goes_right       (goes_right),
		.split_value      (split_value),
		.improve_fraction (improve_fraction),
		.status           (status)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		error_count++;
		$display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	// Best split over the rows held so far. All arithmetic is on 128-bit
	// vectors and wraps, just like the wide accumulators of the block.
	function automatic split_t best_split_of_rows();
		logic [127:0]       wn, s, sq, y, ay, total, best, sl, t, at, q, nl, nr, ratio, as;
		int unsigned        n, mn, i, bpos;
		logic signed [63:0] pair_sum;
		split_t             r;
		n = row_count;
		mn = (min_rows < 1) ? 1 : min_rows;
		wn = n;
		s = '0;
		sq = '0;
		best = '0;
		sl = '0;
		bpos = 0;
		r.right = 1'b0;
		r.imp = '0;
		for (i = 0; i < n; i++) begin
			y = {{96{resp_mem[i][VW-1]}}, resp_mem[i]};
			ay = y[127] ? -y : y;
			s += y;
			sq += ay * ay;
		end
		as = s[127] ? -s : s;
		total = wn * sq - as * as;
		// Rows move from the right side to the left one at a time.
		for (i = 0; i + 1 < n && n - i > mn; i++) begin
			nl = i + 1;
			nr = n - i - 1;
			sl += {{96{resp_mem[i][VW-1]}}, resp_mem[i]};
			if (pred_mem[i + 1] != pred_mem[i] && nl >= mn) begin
				t = wn * sl - nl * s;
				at = t[127] ? -t : t;
				q = (at * at) / (nl * nr);
				// Strictly greater, so the earliest of equal scores stays.
				if (q > best) begin
					best = q;
					bpos = i;
					r.right = ~t[127];
				end
			end
		end
		if (total != 0) begin
			ratio = (best << 16) / total;
			r.imp = (ratio > 128'd65536) ? IMP_ONE : ratio[IMPW-1:0];
		end
		if (n == 0) begin
			r.split = '0;
		end else if (bpos + 1 < n) begin
			pair_sum = 64'(pred_mem[bpos]) + 64'(pred_mem[bpos + 1]);
			r.split = VW'(pair_sum >>> 1);
		end else begin
			r.split = pred_mem[bpos];
		end
		r.pos = bpos[POSW-1:0];
		r.stat = dropped_rows;
		return r;
	endfunction

	// Driver: presents rows from the queue, with random gaps while quiet is low.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			predictor_value <= '0;
			response_value <= '0;
			last_row <= 1'b0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				// Transfer of one row: update the model and pop it.
				if (row_count < CAPACITY) begin
					pred_mem[row_count] = predictor_value;
					resp_mem[row_count] = response_value;
					row_count++;
				end else begin
					dropped_rows = 1'b1;
				end
				if (last_row) begin
					splits_due.push_back(best_split_of_rows());
					row_count = 0;
					dropped_rows = 1'b0;
				end
				void'(rows_to_send.pop_front());
			end
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (rows_to_send.size() > 0 && !quiet
					&& $urandom_range(0, 9) == 0) begin
				gap_left <= $urandom_range(0, 5);
				start <= 1'b0;
			end else if (rows_to_send.size() > 0) begin
				start <= 1'b1;
				predictor_value <= rows_to_send[0].pred;
				response_value <= rows_to_send[0].resp;
				last_row <= rows_to_send[0].last;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: the configuration copy and the result check.
	always @(posedge clk) begin
		split_t e;
		if (arst_n && cfg_valid && cfg_ready)
			min_rows <= cfg_data;
		if (arst_n && result_valid) begin
			if (splits_due.size() == 0) begin
				error_count++;
				$display("%0t: result with nothing expected", $realtime);
			end else begin
				e = splits_due.pop_front();
				if (best_position !== e.pos)
					report_mismatch("best_position", best_position, e.pos);
				if (goes_right !== e.right)
					report_mismatch("goes_right", goes_right, e.right);
				if (split_value !== e.split)
					report_mismatch("split_value", split_value, e.split);
				if (improve_fraction !== e.imp)
					report_mismatch("improve_fraction", improve_fraction, e.imp);
				if (status !== e.stat)
					report_mismatch("status", status, e.stat);
			end
		end
	end

	// Watchdog: counts cycles in which neither a row transfer nor a result happens.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_min_rows(input logic [MNW-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_row(input logic [31:0] p, input logic [31:0] r, input logic l);
		row_t x;
		x.pred = p;
		x.resp = r;
		x.last = l;
		rows_to_send.push_back(x);
	endtask

	// A data set of n rows with random content. Predictors are sorted unless
	// the set is meant as noise; duplicates are made common on purpose.
	task automatic add_random_set(input int n, input bit sorted);
		logic [31:0] preds[$];
		logic [31:0] base;
		int          j, mode;
		mode = $urandom_range(0, 3);
		base = $urandom;
		for (j = 0; j < n; j++) begin
			case (mode)
				0: preds.push_back($urandom);
				1: preds.push_back(base + $urandom_range(0, 3));
				default: preds.push_back($urandom_range(0, 15) << $urandom_range(0, 27));
			endcase
		end
		if (sorted)
			preds.sort() with (signed'(item));
		for (j = 0; j < n; j++)
			add_row(preds[j], (mode == 1) ? $urandom_range(0, 7) << 16 : $urandom,
				j == n - 1);
	endtask

	// Waits until every row is sent and every result has arrived, by which
	// time the block is back to idle.
	task automatic drain();
		while (rows_to_send.size() > 0 || splits_due.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int k, items;
		error_count = 0;
		row_count = 0;
		dropped_rows = 1'b0;
		min_rows = MIN_NODE_RST;
		quiet = 1'b0;
		stall_cycles = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extreme predictors and responses at the reset min_node.
		add_row(32'h8000_0000, 32'h7fff_ffff, 1'b0);
		add_row(32'h8000_0000, 32'h8000_0000, 1'b0);
		add_row(32'h0000_0000, 32'h8000_0000, 1'b0);
		add_row(32'h7fff_fffe, 32'h0000_0005, 1'b0);
		add_row(32'h7fff_ffff, 32'hffff_ffff, 1'b1);
		// A single row, and two rows: no split can satisfy min_node.
		add_row(32'h0001_0000, 32'h0003_0000, 1'b1);
		add_row(32'hffff_0000, 32'h0001_0000, 1'b0);
		add_row(32'h0001_0000, 32'h0002_0000, 1'b1);
		// Constant response: zero total sum of squares.
		for (k = 0; k < 5; k++)
			add_row(k << 16, 32'h0007_0000, k == 4);
		// Alternating responses; at the reset min_node only one split scores above zero.
		add_row(32'd1, 32'd1, 1'b0);
		add_row(32'd2, -32'd1, 1'b0);
		add_row(32'd3, 32'd1, 1'b0);
		add_row(32'd4, -32'd1, 1'b0);
		add_row(32'd5, 32'd1, 1'b0);
		add_row(32'd6, -32'd1, 1'b1);
		drain();

		// min_node of three, then 4096, which no set of five rows can satisfy.
		write_min_rows(13'd3);
		add_random_set(8, 1'b1);
		add_random_set(7, 1'b1);
		drain();
		write_min_rows(13'd4096);
		add_random_set(5, 1'b1);
		drain();

		// Random phases over several min_node settings.
		items = 0;
		for (int phase = 0; phase < 10; phase++) begin
			write_min_rows((phase == 0) ? 13'd2 : 13'($urandom_range(2, 6)));
			if (phase == 8)
				quiet = 1'b1;
			for (k = 0; k < 9; k++) begin
				int n;
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 14);
				add_random_set(n, $urandom_range(0, 9) != 0);
				items += n;
			end
			drain();
		end

		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
